### rtl/cvel_pkg.sv
// Shared constants and types for the cell voltage extreme locator.
`default_nettype none

package cvel_pkg;

    localparam int VOLT_W       = 16;
    localparam int SUM_W        = 23;
    localparam int CELL_COUNT_W = 8;
    localparam int MOD_NUM_W    = 3;
    localparam int CHAN_NUM_W   = 6;
    localparam int NUM_MASKS    = 4;
    localparam int MASK_W       = 32;
    localparam int MASK_SEL_W   = 2;
    localparam int CHAN_SEL_W   = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [SUM_W-1:0]  SUM_LIMIT     = 23'h7fffff;
    localparam logic [VOLT_W-1:0] VOLT_ALL_ONES = 16'hffff;

    localparam logic [CELL_COUNT_W-1:0] CELL_COUNT_RESET   = 8'd128;
    localparam logic [MOD_NUM_W-1:0]    MODULE_COUNT_RESET = 3'd4;
    localparam logic [MASK_W-1:0]       MASK_RESET         = 32'hffffffff;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELL_COUNT   = 3'd0,
        REG_MODULE_COUNT = 3'd1,
        REG_MASK0        = 3'd2,
        REG_MASK1        = 3'd3,
        REG_MASK2        = 3'd4,
        REG_MASK3        = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LOC_IDLE,
        LOC_SEARCH,
        LOC_OUT
    } loc_state_t;

endpackage

`default_nettype wire

### rtl/cell_voltage_extreme_locator_top.sv
// Top level of the cell voltage extreme locator: config registers and front/queue/back.
`default_nettype none

// Cell voltages enter one beat per cycle on the input channel, in logical cell
// order; after cell_count beats (0 taken as 1, capped at MAX_CELLS) the scan
// closes and one result beat carries the highest and lowest voltage, the
// module/channel position of each (first occurrence wins on ties) and the
// saturated pack sum. The front end takes a beat every cycle unless in_stall is
// high and pushes each closed scan into a two-entry record queue; it raises
// in_stall only while that queue is full. The back end pops a record and walks
// the cell-present masks one channel bit per cycle, counting set bits until
// both indexes are mapped or the last channel of the last searched module is
// reached; with a module count of 0 it skips the walk. A locate pass runs from
// the pop through the mask walk to the result beat, which holds while out_stall
// is high. The front end keeps taking cells while earlier scans are located;
// when scans close faster than locate passes finish, the queue fills and
// in_stall holds the input. A position that the masks cannot supply keeps the
// module/channel reported for the previous scan (0 after reset). Configuration
// writes are always taken (cfg_ready is tied high) and should be issued only
// while the block is idle; an unknown register index is dropped.
module cell_voltage_extreme_locator_top #(
    parameter int MAX_MODULES         = 4,
    parameter int CHANNELS_PER_MODULE = 32,
    parameter int MAX_CELLS           = 128
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [cvel_pkg::VOLT_W-1:0]        cell_voltage,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [cvel_pkg::VOLT_W-1:0]             max_voltage,
    output logic [cvel_pkg::MOD_NUM_W-1:0]          max_module,
    output logic [cvel_pkg::CHAN_NUM_W-1:0]         max_channel,
    output logic [cvel_pkg::VOLT_W-1:0]             min_voltage,
    output logic [cvel_pkg::MOD_NUM_W-1:0]          min_module,
    output logic [cvel_pkg::CHAN_NUM_W-1:0]         min_channel,
    output logic [cvel_pkg::SUM_W-1:0]              pack_sum,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cvel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cvel_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cvel_pkg::*;

    // index width of a logical cell within one scan
    localparam int IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    // scan record: max, max index, min, min index, sum
    localparam int REC_W = 2 * VOLT_W + 2 * IDX_W + SUM_W;

    logic [CELL_COUNT_W-1:0]             cell_count_reg;
    logic [MOD_NUM_W-1:0]                module_count_reg;
    logic [NUM_MASKS-1:0][MASK_W-1:0]    mask_reg;

    logic             in_accept;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    logic [REC_W-1:0] push_data;
    logic [REC_W-1:0] pop_data;

    assign cfg_ready = 1'b1;

    // hold the front whenever the record queue has no room
    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    // configuration register file; unknown indexes drop the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg   <= CELL_COUNT_RESET;
            module_count_reg <= MODULE_COUNT_RESET;
            mask_reg         <= {NUM_MASKS{MASK_RESET}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CELL_COUNT:   cell_count_reg   <= cfg_data[CELL_COUNT_W-1:0];
                REG_MODULE_COUNT: module_count_reg <= cfg_data[MOD_NUM_W-1:0];
                REG_MASK0:        mask_reg[0]      <= cfg_data[MASK_W-1:0];
                REG_MASK1:        mask_reg[1]      <= cfg_data[MASK_W-1:0];
                REG_MASK2:        mask_reg[2]      <= cfg_data[MASK_W-1:0];
                REG_MASK3:        mask_reg[3]      <= cfg_data[MASK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    cvel_front #(
        .MAX_CELLS (MAX_CELLS),
        .IDX_W     (IDX_W),
        .REC_W     (REC_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .cell_voltage (cell_voltage),
        .cell_count   (cell_count_reg),
        .push         (push),
        .push_data    (push_data)
    );

    cvel_queue #(
        .REC_W (REC_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    cvel_back #(
        .MAX_MODULES         (MAX_MODULES),
        .CHANNELS_PER_MODULE (CHANNELS_PER_MODULE),
        .IDX_W               (IDX_W),
        .REC_W               (REC_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (pop_data),
        .pop          (pop),
        .module_count (module_count_reg),
        .masks        (mask_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .max_voltage  (max_voltage),
        .max_module   (max_module),
        .max_channel  (max_channel),
        .min_voltage  (min_voltage),
        .min_module   (min_module),
        .min_channel  (min_channel),
        .pack_sum     (pack_sum)
    );

endmodule

`default_nettype wire

### rtl/cvel_front.sv
// Front end: accepts cell beats and keeps running extremes and pack sum.
`default_nettype none

module cvel_front #(
    parameter int MAX_CELLS = 128,
    parameter int IDX_W     = 7,
    parameter int REC_W     = 69
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             accept,
    input  wire logic [cvel_pkg::VOLT_W-1:0]      cell_voltage,
    input  wire logic [cvel_pkg::CELL_COUNT_W-1:0] cell_count,
    output logic                                  push,
    output logic [REC_W-1:0]                      push_data
);
    import cvel_pkg::*;

    localparam int SEEN_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS + 1) : 1;
    localparam int LIM_W  = (SEEN_W > CELL_COUNT_W) ? SEEN_W : CELL_COUNT_W;

    logic [VOLT_W-1:0] max_reg, max_next;
    logic [VOLT_W-1:0] min_reg, min_next;
    logic [IDX_W-1:0]  max_idx_reg, max_idx_next;
    logic [IDX_W-1:0]  min_idx_reg, min_idx_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SEEN_W-1:0] seen_reg, seen_inc;
    logic [SUM_W:0]    sum_wide;
    logic [LIM_W-1:0]  lim_raw, lim;
    logic              scan_end;

    always_comb
    begin
        lim_raw = (cell_count == '0) ? LIM_W'(1) : LIM_W'(cell_count);
        lim     = (lim_raw > LIM_W'(MAX_CELLS)) ? LIM_W'(MAX_CELLS) : lim_raw;

        max_next     = max_reg;
        max_idx_next = max_idx_reg;
        if (cell_voltage > max_reg)
        begin
            max_next     = cell_voltage;
            max_idx_next = IDX_W'(seen_reg);
        end
        min_next     = min_reg;
        min_idx_next = min_idx_reg;
        if (cell_voltage < min_reg)
        begin
            min_next     = cell_voltage;
            min_idx_next = IDX_W'(seen_reg);
        end

        // saturate the pack sum
        sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(cell_voltage);
        sum_next = (sum_wide > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : sum_wide[SUM_W-1:0];

        seen_inc = seen_reg + SEEN_W'(1);
        scan_end = (LIM_W'(seen_inc) >= lim);
        push     = accept && scan_end;
        push_data = {max_next, max_idx_next, min_next, min_idx_next, sum_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg     <= '0;
            min_reg     <= VOLT_ALL_ONES;
            max_idx_reg <= '0;
            min_idx_reg <= '0;
            sum_reg     <= '0;
            seen_reg    <= '0;
        end
        else if (accept)
        begin
            if (scan_end)
            begin
                max_reg     <= '0;
                min_reg     <= VOLT_ALL_ONES;
                max_idx_reg <= '0;
                min_idx_reg <= '0;
                sum_reg     <= '0;
                seen_reg    <= '0;
            end
            else
            begin
                max_reg     <= max_next;
                min_reg     <= min_next;
                max_idx_reg <= max_idx_next;
                min_idx_reg <= min_idx_next;
                sum_reg     <= sum_next;
                seen_reg    <= seen_inc;
            end
        end
    end

    a_seen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        LIM_W'(seen_reg) < LIM_W'(MAX_CELLS))
        else $error("cells seen reached the scan ceiling without closing the scan");

    a_push_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (seen_reg == '0) && (sum_reg == '0))
        else $error("scan state not cleared after closing a scan");

endmodule

`default_nettype wire

### rtl/cvel_queue.sv
// Two-entry queue carrying closed scan records from front to back.
`default_nettype none

module cvel_queue #(
    parameter int REC_W = 69
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [REC_W-1:0] push_data,
    input  wire logic             pop,
    output logic [REC_W-1:0]      pop_data,
    output logic                  full,
    output logic                  empty
);
    import cvel_pkg::*;

    logic [REC_W-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("record pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("record popped from an empty queue");

endmodule

`default_nettype wire

### rtl/cvel_back.sv
// Back end: maps extreme indexes to module/channel by a bit-serial mask walk.
`default_nettype none

module cvel_back #(
    parameter int MAX_MODULES         = 4,
    parameter int CHANNELS_PER_MODULE = 32,
    parameter int IDX_W               = 7,
    parameter int REC_W               = 69
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         q_empty,
    input  wire logic [REC_W-1:0]                             q_data,
    output logic                                              pop,
    input  wire logic [cvel_pkg::MOD_NUM_W-1:0]               module_count,
    input  wire logic [cvel_pkg::NUM_MASKS-1:0][cvel_pkg::MASK_W-1:0] masks,
    output logic                                              out_valid,
    input  wire logic                                         out_stall,
    output logic [cvel_pkg::VOLT_W-1:0]                       max_voltage,
    output logic [cvel_pkg::MOD_NUM_W-1:0]                    max_module,
    output logic [cvel_pkg::CHAN_NUM_W-1:0]                   max_channel,
    output logic [cvel_pkg::VOLT_W-1:0]                       min_voltage,
    output logic [cvel_pkg::MOD_NUM_W-1:0]                    min_module,
    output logic [cvel_pkg::CHAN_NUM_W-1:0]                   min_channel,
    output logic [cvel_pkg::SUM_W-1:0]                        pack_sum
);
    import cvel_pkg::*;

    localparam int MOD_LIMIT = (MAX_MODULES < NUM_MASKS) ? MAX_MODULES : NUM_MASKS;
    localparam int MOD_W     = (MOD_LIMIT > 1) ? $clog2(MOD_LIMIT) : 1;
    localparam int CH_W      = (CHANNELS_PER_MODULE > 1) ? $clog2(CHANNELS_PER_MODULE) : 1;
    localparam int CNT_W     = $clog2(MOD_LIMIT * CHANNELS_PER_MODULE + 1);
    localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    loc_state_t state_reg, state_next;

    logic [VOLT_W-1:0]     cur_max_reg, cur_min_reg;
    logic [IDX_W-1:0]      cur_max_idx_reg, cur_min_idx_reg;
    logic [SUM_W-1:0]      cur_sum_reg;
    logic [MOD_W-1:0]      mod_reg;
    logic [CH_W-1:0]       chan_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  max_found_reg, min_found_reg;
    logic [MOD_NUM_W-1:0]  kept_max_mod_reg, kept_min_mod_reg;
    logic [CHAN_NUM_W-1:0] kept_max_ch_reg, kept_min_ch_reg;

    logic [MOD_NUM_W-1:0]  mods_eff;
    logic                  bit_set, hit_max, hit_min, last_chan, last_mod, walk_done;
    logic [MOD_NUM_W-1:0]  pos_mod;
    logic [CHAN_NUM_W-1:0] pos_ch;

    always_comb
    begin
        mods_eff  = (module_count > MOD_NUM_W'(MOD_LIMIT)) ? MOD_NUM_W'(MOD_LIMIT)
                                                           : module_count;
        bit_set   = masks[MASK_SEL_W'(mod_reg)][CHAN_SEL_W'(chan_reg)];
        hit_max   = bit_set && !max_found_reg &&
                    (CMP_W'(cnt_reg) == CMP_W'(cur_max_idx_reg));
        hit_min   = bit_set && !min_found_reg &&
                    (CMP_W'(cnt_reg) == CMP_W'(cur_min_idx_reg));
        pos_mod   = MOD_NUM_W'(mod_reg) + MOD_NUM_W'(1);
        pos_ch    = CHAN_NUM_W'(chan_reg) + CHAN_NUM_W'(1);
        last_chan = (chan_reg == CH_W'(CHANNELS_PER_MODULE - 1));
        last_mod  = (pos_mod == mods_eff);
        walk_done = (last_chan && last_mod) ||
                    ((max_found_reg || hit_max) && (min_found_reg || hit_min));

        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            LOC_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = (mods_eff == '0) ? LOC_OUT : LOC_SEARCH;
                end
            end
            LOC_SEARCH:
            begin
                if (walk_done)
                begin
                    state_next = LOC_OUT;
                end
            end
            LOC_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = LOC_IDLE;
                end
            end
            default:
            begin
                state_next = LOC_IDLE;
            end
        endcase

        out_valid   = (state_reg == LOC_OUT);
        max_voltage = cur_max_reg;
        max_module  = kept_max_mod_reg;
        max_channel = kept_max_ch_reg;
        min_voltage = cur_min_reg;
        min_module  = kept_min_mod_reg;
        min_channel = kept_min_ch_reg;
        pack_sum    = cur_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LOC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // record payload, latched at pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            {cur_max_reg, cur_max_idx_reg, cur_min_reg, cur_min_idx_reg, cur_sum_reg}
                <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg          <= '0;
            chan_reg         <= '0;
            cnt_reg          <= '0;
            max_found_reg    <= 1'b0;
            min_found_reg    <= 1'b0;
            kept_max_mod_reg <= '0;
            kept_max_ch_reg  <= '0;
            kept_min_mod_reg <= '0;
            kept_min_ch_reg  <= '0;
        end
        else if (pop)
        begin
            mod_reg       <= '0;
            chan_reg      <= '0;
            cnt_reg       <= '0;
            max_found_reg <= 1'b0;
            min_found_reg <= 1'b0;
        end
        else if (state_reg == LOC_SEARCH)
        begin
            // a miss leaves the kept position untouched
            if (hit_max)
            begin
                max_found_reg    <= 1'b1;
                kept_max_mod_reg <= pos_mod;
                kept_max_ch_reg  <= pos_ch;
            end
            if (hit_min)
            begin
                min_found_reg    <= 1'b1;
                kept_min_mod_reg <= pos_mod;
                kept_min_ch_reg  <= pos_ch;
            end
            if (bit_set)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (last_chan)
            begin
                chan_reg <= '0;
                mod_reg  <= mod_reg + MOD_W'(1);
            end
            else
            begin
                chan_reg <= chan_reg + CH_W'(1);
            end
        end
    end

    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg != LOC_IDLE))
        else $error("pop did not start a locate pass");

    a_kept_module_range: assert property (@(posedge clk) disable iff (!rst_n)
        (kept_max_mod_reg <= MOD_NUM_W'(MOD_LIMIT)) &&
        (kept_min_mod_reg <= MOD_NUM_W'(MOD_LIMIT)))
        else $error("kept module number beyond searched modules");

endmodule

`default_nettype wire

### verif/cvel_scan_checker.sv
// Scan checker: predicts each scan summary from the accepted cell beats and compares it.
module cvel_scan_checker #(
    parameter int MAX_MODULES         = 4,
    parameter int CHANNELS_PER_MODULE = 32,
    parameter int MAX_CELLS           = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [cvel_pkg::VOLT_W-1:0]     cell_voltage,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [cvel_pkg::VOLT_W-1:0]     max_voltage,
    input  logic [cvel_pkg::MOD_NUM_W-1:0]  max_module,
    input  logic [cvel_pkg::CHAN_NUM_W-1:0] max_channel,
    input  logic [cvel_pkg::VOLT_W-1:0]     min_voltage,
    input  logic [cvel_pkg::MOD_NUM_W-1:0]  min_module,
    input  logic [cvel_pkg::CHAN_NUM_W-1:0] min_channel,
    input  logic [cvel_pkg::SUM_W-1:0]      pack_sum,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cvel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvel_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatch_count,
    output int                              scans_outstanding
);
    import cvel_pkg::*;

    typedef struct packed {
        logic [VOLT_W-1:0]     max_v;
        logic [MOD_NUM_W-1:0]  max_m;
        logic [CHAN_NUM_W-1:0] max_c;
        logic [VOLT_W-1:0]     min_v;
        logic [MOD_NUM_W-1:0]  min_m;
        logic [CHAN_NUM_W-1:0] min_c;
        logic [SUM_W-1:0]      sum;
    } scan_summary_t;

    scan_summary_t expected_scans[$];

    // shadow of the register file
    logic [CELL_COUNT_W-1:0] cells_per_scan;
    logic [MOD_NUM_W-1:0]    modules_searched;
    logic [MASK_W-1:0]       present_mask [NUM_MASKS];

    // scan in progress
    logic [VOLT_W-1:0]       peak_v;
    logic [VOLT_W-1:0]       low_v;
    logic [6:0]              peak_idx;
    logic [6:0]              low_idx;
    logic [CELL_COUNT_W-1:0] cells_in_scan;
    logic [SUM_W-1:0]        scan_sum;
    logic [MOD_NUM_W-1:0]    peak_mod;
    logic [CHAN_NUM_W-1:0]   peak_chan;
    logic [MOD_NUM_W-1:0]    low_mod;
    logic [CHAN_NUM_W-1:0]   low_chan;

    task automatic restart_scan();
        peak_v        = '0;
        low_v         = VOLT_ALL_ONES;
        peak_idx      = '0;
        low_idx       = '0;
        cells_in_scan = '0;
        scan_sum      = '0;
    endtask

    // Walk the present masks counting set bits; report whether the index was reached.
    function automatic bit locate_cell(input logic [6:0] idx,
                                       output logic [MOD_NUM_W-1:0] mod_no,
                                       output logic [CHAN_NUM_W-1:0] chan_no);
        int mods;
        int hits;
        mods    = modules_searched;
        hits    = 0;
        mod_no  = '0;
        chan_no = '0;
        if (mods > MAX_MODULES) mods = MAX_MODULES;
        if (mods > NUM_MASKS) mods = NUM_MASKS;
        for (int m = 0; m < mods; m++) begin
            for (int c = 0; c < CHANNELS_PER_MODULE && c < MASK_W; c++) begin
                if (present_mask[m][c]) begin
                    if (hits == idx) begin
                        mod_no  = MOD_NUM_W'(m + 1);
                        chan_no = CHAN_NUM_W'(c + 1);
                        return 1'b1;
                    end
                    hits++;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_CELL_COUNT:   cells_per_scan   = value[CELL_COUNT_W-1:0];
            REG_MODULE_COUNT: modules_searched = value[MOD_NUM_W-1:0];
            REG_MASK0:        present_mask[0]  = value[MASK_W-1:0];
            REG_MASK1:        present_mask[1]  = value[MASK_W-1:0];
            REG_MASK2:        present_mask[2]  = value[MASK_W-1:0];
            REG_MASK3:        present_mask[3]  = value[MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic take_cell(input logic [VOLT_W-1:0] v);
        int                    scan_len;
        logic [SUM_W:0]        wide_sum;
        logic [MOD_NUM_W-1:0]  m;
        logic [CHAN_NUM_W-1:0] c;
        scan_summary_t         s;
        scan_len = cells_per_scan;
        if (scan_len < 1) scan_len = 1;
        if (scan_len > MAX_CELLS) scan_len = MAX_CELLS;
        // strict compares: first occurrence keeps the extreme
        if (v > peak_v) begin
            peak_v   = v;
            peak_idx = cells_in_scan[6:0];
        end
        if (v < low_v) begin
            low_v   = v;
            low_idx = cells_in_scan[6:0];
        end
        wide_sum = scan_sum + v;
        scan_sum = (wide_sum > SUM_LIMIT) ? SUM_LIMIT : wide_sum[SUM_W-1:0];
        cells_in_scan++;
        if (cells_in_scan < scan_len) return;
        if (locate_cell(peak_idx, m, c)) begin
            peak_mod  = m;
            peak_chan = c;
        end
        if (locate_cell(low_idx, m, c)) begin
            low_mod  = m;
            low_chan = c;
        end
        s = '{peak_v, peak_mod, peak_chan, low_v, low_mod, low_chan, scan_sum};
        expected_scans.push_back(s);
        restart_scan();
    endtask

    function automatic bit field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got === want) return 1'b0;
        if (mismatch_count < 10)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        return 1'b1;
    endfunction

    task automatic check_summary();
        scan_summary_t want;
        bit            bad;
        if (expected_scans.size() == 0) begin
            if (mismatch_count < 10)
                $display("%0t: summary beat with no scan pending (max %0d min %0d sum %0d)",
                         $time, max_voltage, min_voltage, pack_sum);
            mismatch_count++;
            return;
        end
        want = expected_scans.pop_front();
        bad  = 1'b0;
        bad |= field_differs("max_voltage", want.max_v, max_voltage);
        bad |= field_differs("max_module",  want.max_m, max_module);
        bad |= field_differs("max_channel", want.max_c, max_channel);
        bad |= field_differs("min_voltage", want.min_v, min_voltage);
        bad |= field_differs("min_module",  want.min_m, min_module);
        bad |= field_differs("min_channel", want.min_c, min_channel);
        bad |= field_differs("pack_sum",    want.sum,   pack_sum);
        if (bad) mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cells_per_scan   = CELL_COUNT_RESET;
            modules_searched = MODULE_COUNT_RESET;
            for (int m = 0; m < NUM_MASKS; m++) present_mask[m] = MASK_RESET;
            peak_mod         = '0;
            peak_chan        = '0;
            low_mod          = '0;
            low_chan         = '0;
            restart_scan();
            expected_scans.delete();
            mismatch_count    = 0;
            scans_outstanding <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
            if (in_valid && !in_stall) take_cell(cell_voltage);
            if (out_valid && !out_stall) check_summary();
            scans_outstanding <= expected_scans.size();
        end
    end

endmodule

### verif/cell_voltage_extreme_locator_top_test.sv
// Testbench top for the cell voltage extreme locator: clock, reset, stimulus and verdict.
module cell_voltage_extreme_locator_top_test;

    import cvel_pkg::*;

    localparam int MAX_MODULES         = 4;
    localparam int CHANNELS_PER_MODULE = 32;
    localparam int MAX_CELLS           = 128;

    // upper bound on a locate pass: a walk of every mask bit, plus the pop and the result beat
    localparam int LOCATE_CYCLES = MAX_MODULES * CHANNELS_PER_MODULE + 2;
    localparam int SETTLE_CYCLES = LOCATE_CYCLES + 30;
    localparam int HOLD_CYCLES   = 500;
    localparam int RANDOM_CELLS  = 750;

    // register indexes the block does not decode; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [VOLT_W-1:0]     cell_voltage = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [VOLT_W-1:0]     max_voltage;
    logic [MOD_NUM_W-1:0]  max_module;
    logic [CHAN_NUM_W-1:0] max_channel;
    logic [VOLT_W-1:0]     min_voltage;
    logic [MOD_NUM_W-1:0]  min_module;
    logic [CHAN_NUM_W-1:0] min_channel;
    logic [SUM_W-1:0]      pack_sum;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int mismatch_count;
    int scans_outstanding;

    // bumped by the stimulus to ask the receiver for one long hold-off
    int hold_asked = 0;

    cell_voltage_extreme_locator_top #(
        .MAX_MODULES        (MAX_MODULES),
        .CHANNELS_PER_MODULE(CHANNELS_PER_MODULE),
        .MAX_CELLS          (MAX_CELLS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cell_voltage(cell_voltage),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .max_voltage (max_voltage),
        .max_module  (max_module),
        .max_channel (max_channel),
        .min_voltage (min_voltage),
        .min_module  (min_module),
        .min_channel (min_channel),
        .pack_sum    (pack_sum),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    cvel_scan_checker #(
        .MAX_MODULES        (MAX_MODULES),
        .CHANNELS_PER_MODULE(CHANNELS_PER_MODULE),
        .MAX_CELLS          (MAX_CELLS)
    ) scan_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cell_voltage     (cell_voltage),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .max_voltage      (max_voltage),
        .max_module       (max_module),
        .max_channel      (max_channel),
        .min_voltage      (min_voltage),
        .min_module       (min_module),
        .min_channel      (min_channel),
        .pack_sum         (pack_sum),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .scans_outstanding(scans_outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop: the slowest legal run (one-cell scans, each waiting out a full
    // locate pass and the longest receiver stall) stays well inside this.
    initial
    begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Cell value: plenty of rails and repeats so ties and the all-equal cases recur.
    function automatic logic [VOLT_W-1:0] pick_voltage(input logic [VOLT_W-1:0] prev,
                                                       input bit narrow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return VOLT_ALL_ONES;
        if (r < 26) return prev;
        if (narrow) return VOLT_W'(3300 + $urandom_range(0, 3));
        return VOLT_W'($urandom_range(0, 65535));
    endfunction

    // Receiver: drive out_stall at every falling edge. Honor a hold-off request
    // first, otherwise alternate free runs and stall bursts of random length.
    initial
    begin : receiver
        int hold_served;
        int stall_left;
        int free_left;
        int r;
        hold_served = 0;
        stall_left  = 0;
        free_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served = hold_asked;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (free_left > 0)
            begin
                out_stall <= 1'b0;
                free_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                r = $urandom_range(0, 99);
                // now and then a long stretch with no back-pressure at all
                free_left  = (r < 10) ? $urandom_range(100, 300) : $urandom_range(0, 20);
                stall_left = pick_gap(1'b0);
            end
        end
    end

    // Offer one cell beat after a gap; return once it is taken.
    task automatic push_cell(input logic [VOLT_W-1:0] v, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid     <= 1'b0;
            cell_voltage <= VOLT_W'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        cell_voltage <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_cells(input logic [VOLT_W-1:0] vals[$]);
        foreach (vals[i]) push_cell(vals[i], pick_gap(1'b0));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every pending summary, then give the locate pass
    // room to finish before anything is reconfigured.
    task automatic settle(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (scans_outstanding != 0) @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_masks(input logic [MASK_W-1:0] m0, input logic [MASK_W-1:0] m1,
                               input logic [MASK_W-1:0] m2, input logic [MASK_W-1:0] m3);
        write_reg(REG_MASK0, m0);
        write_reg(REG_MASK1, m1);
        write_reg(REG_MASK2, m2);
        write_reg(REG_MASK3, m3);
    endtask

    function automatic logic [MASK_W-1:0] pick_mask();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return $urandom;
        if (r < 55) return $urandom & $urandom & $urandom;
        if (r < 70) return '0;
        return MASK_RESET;
    endfunction

    initial
    begin : stimulus
        int                cells_sent;
        int                scan_len;
        int                phase_cells;
        int                r;
        bit                burst;
        bit                narrow;
        logic [VOLT_W-1:0] last_cell;
        logic [CELL_COUNT_W-1:0] cells_cfg;

        cells_sent = 0;
        last_cell  = '0;

        // hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // No module searched: neither position is found, so both report the
        // reset value of 0.
        write_reg(REG_CELL_COUNT, 32'd4);
        write_reg(REG_MODULE_COUNT, 32'd0);
        send_cells('{16'd100, 16'd200, 16'd50, 16'd150});

        // Full search; writes to undecoded indexes must change nothing.
        settle(SETTLE_CYCLES);
        write_reg(REG_MODULE_COUNT, 32'd4);
        write_reg(REG_SPARE_LO, 32'd1);
        write_reg(REG_SPARE_HI, 32'h0);
        // all zero, all full scale, then a tie on the maximum
        send_cells('{16'h0000, 16'h0000, 16'h0000, 16'h0000,
                     16'hffff, 16'hffff, 16'hffff, 16'hffff,
                     16'd7, 16'hffff, 16'h0000, 16'hffff});

        // Sparse masks: first and last channel of module one and the first
        // channel of module four are present, so a fourth index is never found
        // and the previous position is held. Module count above four is clamped.
        settle(SETTLE_CYCLES);
        write_masks(32'h8000_0001, 32'h0, 32'h0, 32'h0000_0001);
        write_reg(REG_MODULE_COUNT, 32'd7);
        send_cells('{16'hffff, 16'd0, 16'd5, 16'd9,
                     16'd2, 16'd1, 16'd9, 16'd3,
                     16'd5, 16'd6, 16'd7, 16'd8});

        // Cell count of zero behaves as one: every beat closes a scan.
        settle(SETTLE_CYCLES);
        write_reg(REG_CELL_COUNT, 32'd0);
        send_cells('{16'hffff, 16'h0000});

        // Back-pressure: one-cell scans queue far faster than they are located.
        // Ask for a long receiver hold-off and keep offering beats so the record
        // queue fills and in_stall rises.
        settle(SETTLE_CYCLES);
        write_reg(REG_CELL_COUNT, 32'd1);
        write_reg(REG_MODULE_COUNT, 32'd4);
        write_masks(MASK_RESET, MASK_RESET, MASK_RESET, MASK_RESET);
        hold_asked++;
        repeat (40)
        begin
            last_cell = pick_voltage(last_cell, 1'b0);
            push_cell(last_cell, 0);
            cells_sent++;
        end

        // Random phases: new settings each time, scans of random content. A
        // phase may stop mid-scan, so the next count change lands inside a scan.
        while (cells_sent < RANDOM_CELLS)
        begin
            settle(SETTLE_CYCLES);

            r = $urandom_range(0, 99);
            if (r < 5) cells_cfg = '0;
            else if (r < 45) cells_cfg = CELL_COUNT_W'($urandom_range(1, 8));
            else if (r < 75) cells_cfg = CELL_COUNT_W'($urandom_range(9, 40));
            else if (r < 90) cells_cfg = CELL_COUNT_W'($urandom_range(41, 127));
            else cells_cfg = CELL_COUNT_W'($urandom_range(128, 255));
            scan_len = (cells_cfg == 0) ? 1 : ((cells_cfg > MAX_CELLS) ? MAX_CELLS : cells_cfg);
            write_reg(REG_CELL_COUNT, CFG_DATA_W'(cells_cfg));

            write_reg(REG_MODULE_COUNT,
                      ($urandom_range(0, 99) < 60) ? 32'd4 : CFG_DATA_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 99) < 40)
                write_masks(MASK_RESET, MASK_RESET, MASK_RESET, MASK_RESET);
            else
                write_masks(pick_mask(), pick_mask(), pick_mask(), pick_mask());
            if ($urandom_range(0, 4) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);

            burst  = ($urandom_range(0, 3) == 0);
            narrow = ($urandom_range(0, 3) == 0);
            if (scan_len <= 40)
                phase_cells = $urandom_range(20, 60);
            else
                phase_cells = scan_len * $urandom_range(1, 2) + $urandom_range(0, 5);
            // keep the total near the planned item count
            if (phase_cells > RANDOM_CELLS - cells_sent)
                phase_cells = RANDOM_CELLS - cells_sent;

            repeat (phase_cells)
            begin
                // pause now and then until every pending summary is out
                if ($urandom_range(0, 99) < 2) settle(0);
                last_cell = pick_voltage(last_cell, narrow);
                push_cell(last_cell, pick_gap(burst));
                cells_sent++;
            end
        end

        // Drain, then let any late or spurious beat show up before the verdict.
        settle(SETTLE_CYCLES + 100);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
